/* src/lrut_pkg.sv */
// Shared types and constants for the LRU replacement tracker.
package lrut_pkg;

   localparam int ID_WIDTH         = 6;
   localparam int DEFAULT_CAPACITY = 64;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_ERASE  = 2'd1,
      CMD_VICTIM = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   // Per-cell control for one beat: gap closing enable and append strobe.
   typedef struct packed {
      logic remove_en;
      logic load;
   } cell_ctrl_type;

endpackage

/* src/lrut_cell.sv */
// One slot of the recency chain: holds an id and its valid bit.
module lrut_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  lrut_pkg::cell_ctrl_type       ctrl,
   input  logic [lrut_pkg::ID_WIDTH-1:0] key,
   input  logic [lrut_pkg::ID_WIDTH-1:0] right_id,
   input  logic                          right_valid,
   input  logic                          carry_in,
   output logic [lrut_pkg::ID_WIDTH-1:0] id,
   output logic                          valid,
   output logic                          carry_out
);
   import lrut_pkg::*;

   logic [ID_WIDTH-1:0] id_ff, id_in;
   logic                valid_ff, valid_in;
   logic                shift;

   // The carry marks every slot at or after the removed one.
   assign carry_out = carry_in | (valid_ff & (id_ff == key));
   assign shift     = ctrl.remove_en & carry_out;

   always_comb begin
      id_in    = id_ff;
      valid_in = valid_ff;
      if (ctrl.load) begin
         id_in    = key;
         valid_in = 1'b1;
      end else if (shift) begin
         id_in    = right_id;
         valid_in = right_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      id_ff <= id_in;
   end

   assign id    = id_ff;
   assign valid = valid_ff;

endmodule

/* src/lru_replacement_tracker_unit.sv */
// Top level of the LRU replacement tracker: a chain of id cells ordered by recency.
//
//   channel | direction | fields                          | handshake
//   req_    | in        | command, frame_id               | req_valid / req_ready
//   rsp_    | out       | ok, victim_id, entry_count      | rsp_valid / rsp_ready
//
// For each request beat, the cells of the chain compare the frame id in
// parallel, a carry ripples along the chain from the least recent end to mark the
// slots that close the gap, and the append slot is picked by the entry count.
// One request is taken per cycle unless a held response stalls; the response
// register holds one result; the next request enters in the same cycle it leaves.
// Reset clears the valid bits, the entry count and the response valid flag.
module lru_replacement_tracker_unit #(
   parameter int CAPACITY = lrut_pkg::DEFAULT_CAPACITY
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [1:0]                          req_command,
   input  logic [lrut_pkg::ID_WIDTH-1:0]       req_frame_id,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_ok,
   output logic [lrut_pkg::ID_WIDTH-1:0]       rsp_victim_id,
   output logic [$clog2(CAPACITY+1)-1:0]       rsp_entry_count
);
   import lrut_pkg::*;

   localparam int COUNT_W = $clog2(CAPACITY + 1);

   // Chain wiring. Slot 0 is the least recent entry; the last slot sees an
   // empty neighbor on its right.
   logic [ID_WIDTH-1:0] cell_id    [CAPACITY+1];
   logic [CAPACITY:0]   cell_valid;
   logic [CAPACITY:0]   carry;
   cell_ctrl_type       cell_ctrl  [CAPACITY];

   logic [COUNT_W-1:0]  count_ff, count_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_ok_ff, rsp_ok_in;
   logic [ID_WIDTH-1:0] rsp_victim_ff, rsp_victim_in;

   logic                accept;
   cmd_type             cmd;
   logic                found;
   logic                not_full;
   logic                not_empty;
   logic                insert_ok;
   logic                remove_en;
   logic [COUNT_W-1:0]  append_slot;

   assign req_ready = ~rsp_valid_ff | rsp_ready;
   assign accept    = req_valid & req_ready;
   assign cmd       = cmd_type'(req_command);

   assign not_full  = (count_ff != COUNT_W'(CAPACITY));
   assign not_empty = (count_ff != '0);

   // A victim request forces the carry in at the oldest slot, so the whole
   // chain shifts down by one. For insert and erase the carry starts at the
   // matching slot, and it comes out of the far end only if the id was found.
   assign carry[0] = (cmd == CMD_VICTIM) & not_empty;
   assign found    = carry[CAPACITY];

   assign insert_ok = found | not_full;

   // A refreshed id goes back in at the last occupied slot after the gap closes.
   assign append_slot = found ? (count_ff - COUNT_W'(1)) : count_ff;

   always_comb begin
      remove_en = 1'b0;
      unique case (cmd) inside
         CMD_INSERT, CMD_ERASE, CMD_VICTIM: remove_en = accept;
         default:                           remove_en = 1'b0;
      endcase
   end

   assign cell_id[CAPACITY]    = '0;
   assign cell_valid[CAPACITY] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      assign cell_ctrl[i].remove_en = remove_en;
      assign cell_ctrl[i].load      = accept & (cmd == CMD_INSERT) & insert_ok
                                      & (append_slot == COUNT_W'(i));

      lrut_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (cell_ctrl[i]),
         .key         (req_frame_id),
         .right_id    (cell_id[i+1]),
         .right_valid (cell_valid[i+1]),
         .carry_in    (carry[i]),
         .id          (cell_id[i]),
         .valid       (cell_valid[i]),
         .carry_out   (carry[i+1])
      );
   end

   // Entry count and the response fields for the accepted beat.
   always_comb begin
      count_in      = count_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_victim_in = rsp_victim_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      if (accept) begin
         rsp_valid_in  = 1'b1;
         rsp_ok_in     = 1'b0;
         rsp_victim_in = '0;
         unique case (cmd)
            CMD_INSERT: begin
               rsp_ok_in = insert_ok;
               if (!found && not_full) begin
                  count_in = count_ff + COUNT_W'(1);
               end
            end
            CMD_ERASE: begin
               rsp_ok_in = found;
               if (found) begin
                  count_in = count_ff - COUNT_W'(1);
               end
            end
            CMD_VICTIM: begin
               if (not_empty) begin
                  rsp_ok_in     = 1'b1;
                  rsp_victim_in = cell_id[0];
                  count_in      = count_ff - COUNT_W'(1);
               end
            end
            default: begin
               rsp_ok_in = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ok_ff     <= rsp_ok_in;
      rsp_victim_ff <= rsp_victim_in;
   end

   // The response register holds the count as it stood after its own beat.
   logic [COUNT_W-1:0] rsp_count_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_count_ff <= count_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ok          = rsp_ok_ff;
   assign rsp_victim_id   = rsp_victim_ff;
   assign rsp_entry_count = rsp_count_ff;

   // The occupied slots always match the entry count.
   a_valid_matches_count: assert property (@(posedge clock) disable iff (reset)
      $countones(cell_valid) == int'(count_ff))
      else $error("cell valid bits disagree with entry count");

   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      int'(count_ff) <= CAPACITY)
      else $error("entry count above capacity");

   a_empty_victim_fails: assert property (@(posedge clock) disable iff (reset)
      accept && (cmd == CMD_VICTIM) && (count_ff == '0) |=> rsp_valid && !rsp_ok)
      else $error("victim on an empty set reported success");

endmodule

/* dv/tb_top.sv */
// Self-checking testbench for the LRU replacement tracker unit.
module tb_top;
   import lrut_pkg::*;

   // The block is built at its default capacity. Since there are exactly as many
   // frame ids as slots, a full set already holds every id, so any insert while full
   // is a refresh.
   localparam int TRACK_CAPACITY = DEFAULT_CAPACITY;
   localparam int COUNT_W        = $clog2(TRACK_CAPACITY + 1);
   localparam int RANDOM_ITEMS   = 700;

   typedef struct packed {
      logic                ok;
      logic [ID_WIDTH-1:0] victim_id;
      logic [COUNT_W-1:0]  entry_count;
   } lru_response_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [1:0]          req_command = CMD_NONE;
   logic [ID_WIDTH-1:0] req_frame_id = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_ok;
   logic [ID_WIDTH-1:0] rsp_victim_id;
   logic [COUNT_W-1:0]  rsp_entry_count;

   // Ids in recency order as the testbench expects the block to hold them:
   // index 0 is the least recently inserted id, the last index the most recent.
   logic [ID_WIDTH-1:0] recency_list[$];
   // Responses predicted for accepted request beats, oldest first.
   lru_response_type    awaited_responses[$];
   int                  mismatch_count = 0;
   // Sender pacing: beats left in the current burst before the next gap.
   int                  burst_left = 0;

   lru_replacement_tracker_unit #(
      .CAPACITY(TRACK_CAPACITY)
   ) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_command    (req_command),
      .req_frame_id   (req_frame_id),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_ok         (rsp_ok),
      .rsp_victim_id  (rsp_victim_id),
      .rsp_entry_count(rsp_entry_count)
   );

   initial begin
      forever begin
         #4 clock = ~clock;
      end
   end

   // Applies one request to the expected recency list and returns the response
   // that the block should give for it. An insert first drops the id if it is
   // tracked, then appends it at the most recent end when there is room. An erase
   // drops the id if tracked. A victim pops the least recent id. The unused
   // command changes nothing.
   function automatic lru_response_type predict_response(input cmd_type cmd,
                                                         input logic [ID_WIDTH-1:0] id);
      lru_response_type rsp;
      int               hit_pos;
      rsp = '0;
      hit_pos = -1;
      foreach (recency_list[i]) begin
         if (hit_pos < 0 && recency_list[i] == id) begin
            hit_pos = i;
         end
      end
      case (cmd)
         CMD_INSERT: begin
            if (hit_pos >= 0) begin
               recency_list.delete(hit_pos);
            end
            if (recency_list.size() < TRACK_CAPACITY) begin
               recency_list.push_back(id);
               rsp.ok = 1'b1;
            end
         end
         CMD_ERASE: begin
            if (hit_pos >= 0) begin
               recency_list.delete(hit_pos);
               rsp.ok = 1'b1;
            end
         end
         CMD_VICTIM: begin
            if (recency_list.size() > 0) begin
               rsp.victim_id = recency_list.pop_front();
               rsp.ok = 1'b1;
            end
         end
         default: begin
         end
      endcase
      rsp.entry_count = COUNT_W'(recency_list.size());
      return rsp;
   endfunction

   // Sends one request beat and records its predicted response once the beat is
   // taken. Inputs only change at rising edges, so the handshake seen at the
   // falling edge is the one the block acts on at the next rising edge. After each
   // burst the sender may drop valid for a random gap; the next call raises it
   // again in a later time step.
   task automatic send_request(input cmd_type cmd, input logic [ID_WIDTH-1:0] id);
      int gap;
      req_valid    <= 1'b1;
      req_command  <= cmd;
      req_frame_id <= id;
      @(negedge clock);
      while (!req_ready) begin
         @(negedge clock);
      end
      @(posedge clock);
      awaited_responses.push_back(predict_response(cmd, id));
      burst_left--;
      if (burst_left <= 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if ($urandom_range(0, 15) == 0) begin
            gap = $urandom_range(10, 20);
         end
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
   endtask

   // Picks an id that is tracked about half of the time, so that refreshes and
   // successful erases are common; otherwise any id at all.
   function automatic logic [ID_WIDTH-1:0] pick_frame_id();
      if (recency_list.size() > 0 && $urandom_range(0, 1) == 1) begin
         return recency_list[$urandom_range(0, recency_list.size() - 1)];
      end
      return ID_WIDTH'($urandom_range(0, (1 << ID_WIDTH) - 1));
   endfunction

   // Short directed sequence: empty-set corner cases, the id extremes, a refresh
   // that moves an id to the most recent end, erasing an absent id, erasing from
   // the head and from a single-entry set, and the unused command.
   task automatic test_directed_basics();
      send_request(CMD_VICTIM, 6'd0);
      send_request(CMD_ERASE, 6'd0);
      send_request(CMD_NONE, 6'd63);
      send_request(CMD_INSERT, 6'd0);
      send_request(CMD_INSERT, 6'd63);
      send_request(CMD_INSERT, 6'd42);
      send_request(CMD_INSERT, 6'd0);
      send_request(CMD_ERASE, 6'd21);
      send_request(CMD_ERASE, 6'd63);
      send_request(CMD_NONE, 6'd42);
      send_request(CMD_VICTIM, 6'd63);
      send_request(CMD_VICTIM, 6'd0);
      send_request(CMD_VICTIM, 6'd17);
      send_request(CMD_INSERT, 6'd63);
      send_request(CMD_ERASE, 6'd63);
      send_request(CMD_INSERT, 6'd5);
      send_request(CMD_INSERT, 6'd5);
      send_request(CMD_INSERT, 6'd9);
      send_request(CMD_ERASE, 6'd5);
      send_request(CMD_VICTIM, 6'd0);
   endtask

   // Fills the set with every id in a shuffled order, works on the full set, and
   // then drains it with victims, which must come out in recency order. The last
   // victim hits the empty set again.
   task automatic test_fill_and_drain();
      logic [ID_WIDTH-1:0] fill_order[TRACK_CAPACITY];
      logic [ID_WIDTH-1:0] swap_id;
      logic [ID_WIDTH-1:0] moved_id;
      int                  j;
      for (int i = 0; i < TRACK_CAPACITY; i++) begin
         fill_order[i] = ID_WIDTH'(i);
      end
      for (int i = TRACK_CAPACITY - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap_id = fill_order[i];
         fill_order[i] = fill_order[j];
         fill_order[j] = swap_id;
      end
      foreach (fill_order[i]) begin
         send_request(CMD_INSERT, fill_order[i]);
      end
      // Refreshes while full always succeed and keep the count at capacity.
      send_request(CMD_INSERT, recency_list[0]);
      repeat (3) send_request(CMD_INSERT, pick_frame_id());
      send_request(CMD_NONE, 6'd0);
      moved_id = recency_list[$urandom_range(0, TRACK_CAPACITY - 1)];
      send_request(CMD_ERASE, moved_id);
      send_request(CMD_INSERT, moved_id);
      repeat (TRACK_CAPACITY + 1) send_request(CMD_VICTIM, ID_WIDTH'($urandom()));
   endtask

   // Random traffic. The insert share follows the fill level so that the set
   // wanders between nearly empty and nearly full instead of sticking at one end.
   task automatic test_random_traffic();
      int      roll;
      int      insert_pct;
      cmd_type cmd;
      repeat (RANDOM_ITEMS) begin
         if (recency_list.size() <= 12) begin
            insert_pct = 65;
         end else if (recency_list.size() >= 52) begin
            insert_pct = 30;
         end else begin
            insert_pct = 45;
         end
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            cmd = CMD_NONE;
         end else if (roll < 5 + insert_pct) begin
            cmd = CMD_INSERT;
         end else if ($urandom_range(0, 1) == 0) begin
            cmd = CMD_ERASE;
         end else begin
            cmd = CMD_VICTIM;
         end
         if (cmd == CMD_INSERT || cmd == CMD_ERASE) begin
            send_request(cmd, pick_frame_id());
         end else begin
            send_request(cmd, ID_WIDTH'($urandom()));
         end
      end
   endtask

   // Response-side stall pattern: the receiver switches between stretches of
   // always ready, coin-flip readiness, mostly stalled readiness and strict alternation.
   initial begin
      int mode;
      int span;
      int phase;
      phase = 0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(20, 150);
         repeat (span) begin
            @(posedge clock);
            phase++;
            case (mode)
               0: rsp_ready <= 1'b1;
               1: rsp_ready <= $urandom_range(0, 1);
               2: rsp_ready <= ($urandom_range(0, 3) == 0);
               default: rsp_ready <= phase[0];
            endcase
         end
      end
   end

   // Each response beat is checked against the oldest prediction. Like the
   // request side, the handshake is looked at on the falling edge, where it
   // already equals what the next rising edge will take.
   always @(negedge clock) begin
      lru_response_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_responses.size() == 0) begin
            $error("unexpected response beat: ok=%0b victim_id=%0d entry_count=%0d",
                   rsp_ok, rsp_victim_id, rsp_entry_count);
            mismatch_count++;
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_ok !== want.ok) begin
               $error("ok mismatch: expected %0b, actual %0b", want.ok, rsp_ok);
               mismatch_count++;
            end
            if (rsp_victim_id !== want.victim_id) begin
               $error("victim_id mismatch: expected %0d, actual %0d",
                      want.victim_id, rsp_victim_id);
               mismatch_count++;
            end
            if (rsp_entry_count !== want.entry_count) begin
               $error("entry_count mismatch: expected %0d, actual %0d",
                      want.entry_count, rsp_entry_count);
               mismatch_count++;
            end
         end
      end
   end

   // Hard stop in case the block hangs on either handshake.
   initial begin
      #4000000;
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      burst_left = $urandom_range(1, 24);
      test_directed_basics();
      test_fill_and_drain();
      test_random_traffic();
      req_valid <= 1'b0;
      // Drain the responses still owed, then keep watching so that any
      // extra beat from the block is caught as unexpected.
      while (awaited_responses.size() != 0) begin
         @(posedge clock);
      end
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
